/* src/tsp_pkg.sv */
package tsp_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_PLAY = 2'd1;
	localparam logic [1:0] CMD_STOP = 2'd2;

	localparam int SOUND_SLOTS = 12;
	localparam int ROM_SIZE    = 46;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] sound_id;
		logic       force_req;
	} in_word_t;

	typedef struct packed {
		logic [11:0] tone_freq;
		logic        busy_res;
	} out_word_t;

	typedef struct packed {
		logic        playing;
		logic [5:0]  note_addr;
		logic [3:0]  notes_left;
		logic [9:0]  wait_ms;
		logic [11:0] current_tone;
	} player_state_t;

	typedef struct packed {
		logic [11:0] freq;
		logic [9:0]  ms;
	} note_t;

	typedef struct packed {
		logic [5:0] start;
		logic [3:0] len;
	} tune_t;

	// note table, addresses past the end read entry 0
	function automatic note_t note_rom(input logic [5:0] addr);
		note_t n;
		case (addr)
			6'd0:  n = '{12'd1200, 10'd80};
			6'd1:  n = '{12'd800,  10'd40};
			6'd2:  n = '{12'd1100, 10'd40};
			6'd3:  n = '{12'd1500, 10'd50};
			6'd4:  n = '{12'd1400, 10'd45};
			6'd5:  n = '{12'd1000, 10'd45};
			6'd6:  n = '{12'd650,  10'd60};
			6'd7:  n = '{12'd988,  10'd70};
			6'd8:  n = '{12'd1319, 10'd220};
			6'd9:  n = '{12'd160,  10'd120};
			6'd10: n = '{12'd0,    10'd30};
			6'd11: n = '{12'd160,  10'd120};
			6'd12: n = '{12'd523,  10'd110};
			6'd13: n = '{12'd0,    10'd25};
			6'd14: n = '{12'd523,  10'd110};
			6'd15: n = '{12'd0,    10'd25};
			6'd16: n = '{12'd523,  10'd110};
			6'd17: n = '{12'd0,    10'd25};
			6'd18: n = '{12'd659,  10'd180};
			6'd19: n = '{12'd784,  10'd140};
			6'd20: n = '{12'd1047, 10'd450};
			6'd21: n = '{12'd392,  10'd250};
			6'd22: n = '{12'd370,  10'd250};
			6'd23: n = '{12'd349,  10'd250};
			6'd24: n = '{12'd330,  10'd600};
			6'd25: n = '{12'd900,  10'd150};
			6'd26: n = '{12'd1200, 10'd150};
			6'd27: n = '{12'd900,  10'd150};
			6'd28: n = '{12'd1200, 10'd150};
			6'd29: n = '{12'd900,  10'd150};
			6'd30: n = '{12'd1200, 10'd150};
			6'd31: n = '{12'd523,  10'd60};
			6'd32: n = '{12'd659,  10'd60};
			6'd33: n = '{12'd784,  10'd60};
			6'd34: n = '{12'd1047, 10'd60};
			6'd35: n = '{12'd1319, 10'd60};
			6'd36: n = '{12'd1568, 10'd160};
			6'd37: n = '{12'd2400, 10'd15};
			6'd38: n = '{12'd2000, 10'd15};
			6'd39: n = '{12'd1600, 10'd15};
			6'd40: n = '{12'd1300, 10'd15};
			6'd41: n = '{12'd1000, 10'd15};
			6'd42: n = '{12'd800,  10'd15};
			6'd43: n = '{12'd600,  10'd15};
			6'd44: n = '{12'd450,  10'd20};
			6'd45: n = '{12'd2200, 10'd25};
			default: n = '{12'd1200, 10'd80};
		endcase
		return n;
	endfunction

	// start address and note count of each tune
	function automatic tune_t tune_info(input logic [3:0] id);
		tune_t t;
		case (id)
			4'd1:  t = '{6'd0,  4'd1};
			4'd2:  t = '{6'd1,  4'd3};
			4'd3:  t = '{6'd4,  4'd3};
			4'd4:  t = '{6'd7,  4'd2};
			4'd5:  t = '{6'd9,  4'd3};
			4'd6:  t = '{6'd12, 4'd9};
			4'd7:  t = '{6'd21, 4'd4};
			4'd8:  t = '{6'd25, 4'd6};
			4'd9:  t = '{6'd31, 4'd6};
			4'd10: t = '{6'd37, 4'd8};
			4'd11: t = '{6'd45, 4'd1};
			default: t = '{6'd0, 4'd0};
		endcase
		return t;
	endfunction

endpackage

/* src/tone_sequence_player.sv */
// a command word waits in stage 1 once accepted; its result word is registered
//   as it leaves. throughput: one word per cycle unless out_ready stalls; the
//   state updates in one pass of tick/play/stop logic and a single note rom lookup
// reset (arst_n low, asynchronous): player idle and silent, buzzer_enable set,
//   input and output stages empty
module tone_sequence_player (
	input  logic                  clk,
	input  logic                  arst_n,
	// command words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tsp_pkg::in_word_t     in_data,
	// result words
	output logic                  out_valid,
	input  logic                  out_ready,
	output tsp_pkg::out_word_t    out_data,
	// buzzer_enable register write
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data
);

	// input stage
	logic                   valid_s1;
	tsp_pkg::in_word_t      item_s1;

	// player state and its next value
	tsp_pkg::player_state_t state_q;
	tsp_pkg::player_state_t state_next;

	// output register
	logic                   out_valid_q;
	tsp_pkg::out_word_t     result_q;

	logic                   buzzer_enable_q;
	logic                   advance;

	// the stage-1 word moves on when the output register is free or being drained
	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

	// config register: the user writes it only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buzzer_enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			buzzer_enable_q <= cfg_data;
		end
	end

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// next-state logic: countdown, note load, tune start, stop
	tsp_step u_step (
		.cur           (state_q),
		.item          (item_s1),
		.buzzer_enable (buzzer_enable_q),
		.nxt           (state_next)
	);

	// player state commits as the word leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// output register holds a word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.tone_freq <= state_next.current_tone;
			result_q.busy_res  <= state_next.playing;
		end
	end

	// an idle player is always silent
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.playing |-> state_q.current_tone == 12'd0)
		else $error("idle player has a nonzero tone");

	// a stop reaching the output gives a silent, idle word
	a_stop_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.cmd == tsp_pkg::CMD_STOP |=>
			out_valid_q && !result_q.busy_res && result_q.tone_freq == 12'd0)
		else $error("stop did not silence the result");

	// an empty output register never stalls the input side
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

/* src/tsp_step.sv */
module tsp_step (
	input  tsp_pkg::player_state_t cur,
	input  tsp_pkg::in_word_t      item,
	input  logic                   buzzer_enable,
	output tsp_pkg::player_state_t nxt
);

	logic [9:0]     wait_dec;
	tsp_pkg::note_t note;
	tsp_pkg::tune_t tune;
	logic           id_ok;

	assign wait_dec = (cur.wait_ms != 10'd0) ? cur.wait_ms - 10'd1 : 10'd0;
	assign note     = tsp_pkg::note_rom(cur.note_addr);
	assign tune     = tsp_pkg::tune_info(item.sound_id);
	assign id_ok    = (item.sound_id != 4'd0) && (item.sound_id < 4'(tsp_pkg::SOUND_SLOTS));

	always_comb begin
		nxt = cur;
		case (item.cmd)
			tsp_pkg::CMD_TICK: begin
				if (cur.playing) begin
					if (wait_dec != 10'd0) begin
						nxt.wait_ms = wait_dec;
					end else if (cur.notes_left == 4'd0) begin
						nxt.wait_ms      = wait_dec;
						nxt.playing      = 1'b0;
						nxt.current_tone = 12'd0;
					end else begin
						nxt.current_tone = note.freq;
						nxt.wait_ms      = note.ms;
						nxt.note_addr    = cur.note_addr + 6'd1;
						nxt.notes_left   = cur.notes_left - 4'd1;
					end
				end
			end
			tsp_pkg::CMD_PLAY: begin
				if ((item.force_req || buzzer_enable) && id_ok) begin
					nxt.note_addr  = tune.start;
					nxt.notes_left = tune.len;
					nxt.wait_ms    = 10'd0;
					nxt.playing    = 1'b1;
				end
			end
			tsp_pkg::CMD_STOP: begin
				nxt.playing      = 1'b0;
				nxt.current_tone = 12'd0;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

// unused command code, the player must ignore it
localparam logic [1:0] CMD_SPARE = 2'd3;

// expected tone and busy flag after every command word
class tone_scoreboard;
	bit [11:0] pitch_hz [tsp_pkg::ROM_SIZE] = '{
		1200, 800, 1100, 1500, 1400, 1000, 650, 988, 1319, 160, 0, 160,
		523, 0, 523, 0, 523, 0, 659, 784, 1047, 392, 370, 349, 330,
		900, 1200, 900, 1200, 900, 1200, 523, 659, 784, 1047, 1319, 1568,
		2400, 2000, 1600, 1300, 1000, 800, 600, 450, 2200};
	bit [9:0] span_ms [tsp_pkg::ROM_SIZE] = '{
		80, 40, 40, 50, 45, 45, 60, 70, 220, 120, 30, 120,
		110, 25, 110, 25, 110, 25, 180, 140, 450, 250, 250, 250, 600,
		150, 150, 150, 150, 150, 150, 60, 60, 60, 60, 60, 160,
		15, 15, 15, 15, 15, 15, 15, 20, 25};
	bit [5:0] tune_first [tsp_pkg::SOUND_SLOTS] =
		'{0, 0, 1, 4, 7, 9, 12, 21, 25, 31, 37, 45};
	bit [3:0] tune_notes [tsp_pkg::SOUND_SLOTS] =
		'{0, 1, 3, 3, 2, 3, 9, 4, 6, 6, 8, 1};

	bit        enabled = 1'b1;
	bit        sounding;
	bit [5:0]  next_note;
	bit [3:0]  notes_to_go;
	bit [9:0]  hold_ms;
	bit [11:0] tone;

	tsp_pkg::out_word_t expected_tones[$];
	int                 errors;

	function void set_enable(bit v);
		enabled = v;
	endfunction

	function void note_command(tsp_pkg::in_word_t w);
		tsp_pkg::out_word_t e;
		bit [5:0] a;
		case (w.cmd)
			tsp_pkg::CMD_TICK: begin
				if (sounding) begin
					if (hold_ms != 0)
						hold_ms--;
					if (hold_ms == 0) begin
						if (notes_to_go == 0) begin
							sounding = 1'b0;
							tone = '0;
						end else begin
							a = (next_note < tsp_pkg::ROM_SIZE) ? next_note : 6'd0;
							tone = pitch_hz[a];
							hold_ms = span_ms[a];
							next_note++;
							notes_to_go--;
						end
					end
				end
			end
			tsp_pkg::CMD_PLAY: begin
				if ((w.force_req || enabled) && w.sound_id != 0 &&
						w.sound_id < tsp_pkg::SOUND_SLOTS) begin
					next_note = tune_first[w.sound_id];
					notes_to_go = tune_notes[w.sound_id];
					hold_ms = '0;
					sounding = 1'b1;
				end
			end
			tsp_pkg::CMD_STOP: begin
				sounding = 1'b0;
				tone = '0;
			end
			default: ;
		endcase
		e.tone_freq = tone;
		e.busy_res = sounding;
		expected_tones.push_back(e);
	endfunction

	function void check_tone(tsp_pkg::out_word_t got);
		tsp_pkg::out_word_t e;
		if (expected_tones.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result word: tone %0d busy %0b", got.tone_freq,
					got.busy_res);
			return;
		end
		e = expected_tones.pop_front();
		if (got.tone_freq !== e.tone_freq || got.busy_res !== e.busy_res) begin
			errors++;
			if (errors <= 10)
				$display("mismatch: tone exp %0d got %0d, busy exp %0b got %0b",
					e.tone_freq, got.tone_freq, e.busy_res, got.busy_res);
		end
	endfunction

	function int pending();
		return expected_tones.size();
	endfunction

	function bit all_good();
		return errors == 0 && expected_tones.size() == 0;
	endfunction
endclass

module tb_top;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	tsp_pkg::in_word_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	tsp_pkg::out_word_t out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_data = 1'b0;

	// set by the stimulus thread for a stretch where neither side idles
	bit        steady;
	int        words_sent;

	tone_scoreboard sb = new();

	tone_sequence_player dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the handshake hangs
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// offer one command word, with random idle cycles ahead of it;
	// returns in the time step of the accepting edge with in_valid still high
	task automatic send_word(tsp_pkg::in_word_t w);
		while (!steady && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		sb.note_command(w);
		words_sent++;
	endtask

	task automatic send_cmd(logic [1:0] cmd, logic [3:0] id, logic frc);
		tsp_pkg::in_word_t w;
		w.cmd = cmd;
		w.sound_id = id;
		w.force_req = frc;
		send_word(w);
	endtask

	// buzzer_enable is only written with nothing in flight
	task automatic write_enable(bit v);
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_enable(v);
	endtask

	// mostly short tunes so that their ends are reached often
	function automatic logic [3:0] pick_tune();
		case ($urandom_range(9))
			0: return 4'd1;
			1: return 4'd11;
			2: return 4'd10;
			3: return 4'd2;
			4: return 4'd3;
			5: return 4'd4;
			default: return 4'($urandom_range(1, 11));
		endcase
	endfunction

	// well-formed run: a play and a burst of ticks, with the odd stray command
	task automatic play_episode();
		int n;
		int r;
		send_cmd(tsp_pkg::CMD_PLAY, pick_tune(), 1'($urandom_range(1)));
		n = $urandom_range(10, 160);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 3)
				send_cmd(2'($urandom_range(3)), 4'($urandom_range(15)),
					1'($urandom_range(1)));
			else if (r < 5)
				send_cmd(tsp_pkg::CMD_PLAY, pick_tune(), 1'($urandom_range(1)));
			else if (r < 6)
				send_cmd(tsp_pkg::CMD_STOP, 4'($urandom_range(15)),
					1'($urandom_range(1)));
			else
				send_cmd(tsp_pkg::CMD_TICK, 4'($urandom_range(15)),
					1'($urandom_range(1)));
		end
	endtask

	// result side: random back-pressure plus one long hold-off that lets the
	// player fill up and stall the command side
	initial begin
		int hold_left;
		int results_seen;
		hold_left = 0;
		results_seen = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				sb.check_tone(out_data);
				results_seen++;
				if (results_seen == 300)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (steady)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(99) >= 26);
		end
	end

	initial begin
		int phase;
		int stop_at;
		int r;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle corner cases, with field extremes
		send_cmd(tsp_pkg::CMD_TICK, 4'd15, 1'b1);    // tick while idle
		send_cmd(tsp_pkg::CMD_STOP, 4'd0, 1'b0);     // stop while idle
		send_cmd(CMD_SPARE, 4'd15, 1'b1);            // unused code
		send_cmd(tsp_pkg::CMD_PLAY, 4'd0, 1'b1);     // invalid tune id zero
		send_cmd(tsp_pkg::CMD_PLAY, 4'd12, 1'b0);    // first id past the table
		send_cmd(tsp_pkg::CMD_PLAY, 4'd15, 1'b1);    // largest id
		// short tune, then restart with another while it sounds
		send_cmd(tsp_pkg::CMD_PLAY, 4'd11, 1'b0);
		send_cmd(tsp_pkg::CMD_TICK, 4'd0, 1'b0);
		send_cmd(tsp_pkg::CMD_TICK, 4'd0, 1'b0);
		send_cmd(tsp_pkg::CMD_PLAY, 4'd1, 1'b0);     // old tone holds until next tick
		send_cmd(tsp_pkg::CMD_TICK, 4'd0, 1'b0);
		send_cmd(tsp_pkg::CMD_STOP, 4'd15, 1'b1);
		// buzzer disabled: unforced play ignored, forced play goes through
		write_enable(1'b0);
		send_cmd(tsp_pkg::CMD_PLAY, 4'd2, 1'b0);
		send_cmd(tsp_pkg::CMD_TICK, 4'd0, 1'b0);
		send_cmd(tsp_pkg::CMD_PLAY, 4'd2, 1'b1);
		send_cmd(tsp_pkg::CMD_TICK, 4'd0, 1'b0);
		send_cmd(tsp_pkg::CMD_TICK, 4'd0, 1'b0);
		send_cmd(tsp_pkg::CMD_PLAY, 4'd10, 1'b0);    // ignored, tune 2 goes on
		send_cmd(tsp_pkg::CMD_TICK, 4'd0, 1'b0);
		send_cmd(tsp_pkg::CMD_STOP, 4'd0, 1'b0);
		write_enable(1'b1);

		// random phases, alternating the enable; phase 2 runs without idling
		for (phase = 0; phase < 4; phase++) begin
			write_enable((phase % 2) == 0);
			steady = (phase == 2);
			stop_at = words_sent + 250;
			while (words_sent < stop_at) begin
				r = $urandom_range(99);
				if (r < 70)
					play_episode();
				else if (r < 80)
					send_cmd(tsp_pkg::CMD_STOP, 4'($urandom_range(15)),
						1'($urandom_range(1)));
				else
					send_cmd(2'($urandom_range(3)), 4'($urandom_range(15)),
						1'($urandom_range(1)));
			end
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// drain and give the pipeline a few more cycles
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.all_good())
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
